### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// This macro checks that a property holds at every clock edge outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// This macro checks that a condition never holds outside reset.
`define CHK_NEVER(lbl, cond, msg) \
    `CHK_ASSERT(lbl, !(cond), msg)

`endif

### rtl/core/lcgr_pkg.sv
`default_nettype none

package lcgr_pkg;

    localparam int DATA_W = 32;
    localparam int DRAW_W = 15;
    localparam int OP_W   = 3;

    // Generator step: state * 214013 + 2531011, modulo 2^32.
    localparam logic [DATA_W-1:0] LCG_MUL = 32'd214013;
    localparam logic [DATA_W-1:0] LCG_ADD = 32'd2531011;

    // Modulus of the unit fraction draw.
    localparam logic [DATA_W-1:0] UNIT_MOD = 32'd32767;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_RESEED = 3'd0;
    localparam logic [OP_W-1:0] OP_RAW    = 3'd1;
    localparam logic [OP_W-1:0] OP_RANGE  = 3'd2;
    localparam logic [OP_W-1:0] OP_UNIT   = 3'd3;
    localparam logic [OP_W-1:0] OP_BOOL   = 3'd4;

    // Register word index of the start seed (paddr bit 2).
    localparam logic REG_START_SEED = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_START,
        ST_WAIT,
        ST_FINISH,
        ST_OUT
    } lcgr_state_t;

    typedef struct packed {
        logic load;
        logic advance;
    } lcgr_gen_ctrl_t;

    typedef struct packed {
        logic              start;
        logic [DRAW_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } lcgr_mod_req_t;

endpackage

`default_nettype wire

### rtl/core/lcgr_mod_unit.sv
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle, DRAW_W dividend bits per request.
module lcgr_mod_unit
    import lcgr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lcgr_mod_req_t     req,
    output logic                   done,
    output logic [DRAW_W-1:0]      remainder
);

    localparam int CNT_W = $clog2(DRAW_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DRAW_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DRAW_W-1:0] rem_reg, rem_next;
    logic [DRAW_W-1:0] dvd_reg, dvd_next;
    logic [DATA_W-1:0] div_reg, div_next;

    logic [DRAW_W:0]   trial;
    logic              fits;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DRAW_W-1]};
        fits  = {{(DATA_W-DRAW_W-1){1'b0}}, trial} >= div_reg;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = req.dividend;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // When the trial fits, the divisor is below 2^16, so its low bits suffice.
            if (fits)
            begin
                rem_next = DRAW_W'(trial - div_reg[DRAW_W:0]);
            end
            else
            begin
                rem_next = trial[DRAW_W-1:0];
            end
            dvd_next = {dvd_reg[DRAW_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_CNT)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### rtl/core/lcgr_gen.sv
`default_nettype none

// Generator state register with its multiply-add step and seed load.
module lcgr_gen
    import lcgr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lcgr_gen_ctrl_t    ctrl,
    input  wire logic [DATA_W-1:0] seed,
    output logic [DATA_W-1:0]      state
);

    logic [DATA_W-1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        if (ctrl.load)
        begin
            state_next = seed;
        end
        else if (ctrl.advance)
        begin
            state_next = DATA_W'(state_reg * LCG_MUL + LCG_ADD);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

`default_nettype wire

### rtl/core/lcg_random_with_range_modes.sv
// Sequence: a reseed, raw, boolean, unused-opcode or empty-span range request passes from
// acceptance through the step, finish and out states; other range requests and unit fraction
// requests also pass the start and wait states, where the 15-step remainder unit runs.
// Throughput: one request at a time; the next can be taken the cycle after the result is taken.
// Reset: rst_n is asynchronous and active low; it clears the generator state, the start
// seed register and the sequencer, and leaves the block idle and ready.
`default_nettype none

// Random number generator with several draw modes.
//
// The block holds a 32-bit linear congruential generator. A request carries an opcode and,
// for range draws, the bounds of the range. Every opcode except reseed steps the generator
// once, and bits 30 to 16 of the new state form the 15-bit draw. The opcode then decides how
// the draw is turned into a result:
//   - reseed copies the start seed register into the generator and returns 0,
//   - raw returns the draw itself,
//   - range returns range_low plus the draw modulo the span, wrapping modulo 2^32,
//   - unit fraction returns the draw modulo 32767,
//   - boolean returns 1 when the draw is nonzero.
// A range draw whose span (range_high - range_low + 1, read as signed) is zero or negative
// returns 0 with bad_range set. Unused opcodes step the generator and return 0.
//
// The sequencer walks the states idle, step, start, wait, finish and out. The step state
// updates the generator. Positive-span range and unit fraction requests then hand the draw to a shared
// remainder unit that retires one dividend bit per cycle. The finish state forms the result
// in the output register, and the out state holds it until the downstream side takes it.
module lcg_random_with_range_modes
    import lcgr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,

    // Request channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // opcode [2:0], range_low [34:3], range_high [66:35]

    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // value [31:0]
    output logic [0:0]       m_tuser    // bad_range [0]
);

    lcgr_state_t       state_reg, state_next;

    logic [DATA_W-1:0] start_seed_reg;

    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] lo_reg;
    logic [DATA_W-1:0] span_reg;
    logic              span_ok_reg;

    logic [DATA_W-1:0] value_reg, value_next;
    logic              bad_reg, bad_next;

    logic [DATA_W-1:0] in_lo;
    logic [DATA_W-1:0] in_hi;
    logic [DATA_W-1:0] in_span;
    logic              in_accept;

    lcgr_gen_ctrl_t    gen_ctrl;
    logic [DATA_W-1:0] gen_state;
    logic [DRAW_W-1:0] draw;

    lcgr_mod_req_t     mod_req;
    logic              mod_done;
    logic [DRAW_W-1:0] mod_rem;

    // Configuration register. Only the word address is decoded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_seed_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_START_SEED))
        begin
            start_seed_reg <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_START_SEED) ? start_seed_reg : '0;

    // Request capture. The span is formed here so that its sign is ready for the step state.
    assign in_lo     = s_tdata[34:3];
    assign in_hi     = s_tdata[66:35];
    assign in_span   = in_hi - in_lo + 1'b1;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg      <= s_tdata[2:0];
            lo_reg      <= in_lo;
            span_reg    <= in_span;
            span_ok_reg <= (in_span != '0) && !in_span[DATA_W-1];
        end
    end

    // Generator and the shared remainder unit.
    lcgr_gen u_gen
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (gen_ctrl),
        .seed  (start_seed_reg),
        .state (gen_state)
    );

    assign draw = gen_state[30:16];

    lcgr_mod_unit u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mod_req),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (((op_reg == OP_RANGE) && span_ok_reg) || (op_reg == OP_UNIT))
                begin
                    state_next = ST_START;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mod_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        s_tready         = 1'b0;
        m_tvalid         = 1'b0;
        gen_ctrl.load    = 1'b0;
        gen_ctrl.advance = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = draw;
        mod_req.divisor  = (op_reg == OP_UNIT) ? UNIT_MOD : span_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_STEP:
            begin
                gen_ctrl.load    = (op_reg == OP_RESEED);
                gen_ctrl.advance = (op_reg != OP_RESEED);
            end
            ST_START:
            begin
                mod_req.start = 1'b1;
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Result formation, done once in the finish state.
    always_comb
    begin
        value_next = '0;
        bad_next   = 1'b0;
        case (op_reg)
            OP_RAW:
            begin
                value_next = {{(DATA_W-DRAW_W){1'b0}}, draw};
            end
            OP_RANGE:
            begin
                if (span_ok_reg)
                begin
                    value_next = lo_reg + {{(DATA_W-DRAW_W){1'b0}}, mod_rem};
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
            OP_UNIT:
            begin
                value_next = {{(DATA_W-DRAW_W){1'b0}}, mod_rem};
            end
            OP_BOOL:
            begin
                value_next = {{(DATA_W-1){1'b0}}, (draw != '0)};
            end
            default:
            begin
                value_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH)
        begin
            value_reg <= value_next;
            bad_reg   <= bad_next;
        end
    end

    assign m_tdata    = value_reg;
    assign m_tuser[0] = bad_reg;

endmodule

`default_nettype wire

### rtl/core/lcgr_checker.sv
`default_nettype none

`include "assert_macros.svh"

// Port-level checks of the generator's request and result channels.
module lcgr_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic [0:0]  m_tuser
);

    // The block takes no request while a result is pending.
    `CHK_NEVER(a_ready_while_result, s_tready && m_tvalid, "ready while a result is pending")

    // An accepted request makes the block busy in the next cycle.
    `CHK_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "ready after accept")

    // A flagged range error always carries a zero value.
    `CHK_ASSERT(a_bad_range_zero, m_tvalid && m_tuser[0] |-> m_tdata == 32'd0, "bad range value")

    // A stalled result holds its value.
    `CHK_ASSERT(a_result_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
        "result changed while stalled")

endmodule

bind lcg_random_with_range_modes lcgr_checker u_lcgr_checker (.*);

`default_nettype wire
